@@ hw/rtl/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and controller/datapath link types for the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Request codes
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Character and attribute constants
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_BLANK   = 8'h20;
    localparam logic [7:0] ATTR_RESET   = 8'h0F;

    // Screen memory write source
    typedef logic [1:0] t_wr_sel;
    localparam t_wr_sel WR_NONE  = 2'd0;
    localparam t_wr_sel WR_ZERO  = 2'd1;
    localparam t_wr_sel WR_BLANK = 2'd2;
    localparam t_wr_sel WR_CHAR  = 2'd3;

    // Cursor update
    typedef logic [2:0] t_cur_op;
    localparam t_cur_op CUR_HOLD    = 3'd0;
    localparam t_cur_op CUR_ZERO    = 3'd1;
    localparam t_cur_op CUR_BACK    = 3'd2;
    localparam t_cur_op CUR_NEWLINE = 3'd3;
    localparam t_cur_op CUR_ADVANCE = 3'd4;

    // Controller to datapath commands
    typedef struct packed {
        logic    capture;     // latch the request fields
        logic    sweep_clr;   // restart the sweep counter
        logic    sweep_inc;   // step the sweep counter
        logic    rd_copy;     // read the cell one row below the sweep
        logic    copy_issue;  // a scroll read is in flight
        t_wr_sel wr_sel;
        t_cur_op cur_op;
        logic    emit;        // send a result
        logic    emit_rd;     // result carries the read cell
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic is_read;
        logic char_zero;
        logic char_nl;
        logic idx_ok;
        logic cur_end;
        logic copy_last;
        logic cells_last;
    } t_dp_stat;

endpackage

@@ hw/rtl/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Request sequencer: decodes each item and steps the datapath through the
// reset clear, scroll, clear and read sequences.
// ----------------------------------------------------------------------------
module tcw_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output tcw_pkg::t_dp_cmd  o_cmd,
    input  tcw_pkg::t_dp_stat i_stat
);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECODE = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_COPY   = 3'd4;
    localparam logic [2:0] ST_DRAIN  = 3'd5;
    localparam logic [2:0] ST_FILL   = 3'd6;
    localparam logic [2:0] ST_CLEAR  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_busy = (r_state != ST_IDLE);

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_INIT: begin
                // zero the screen after reset
                o_cmd.wr_sel    = tcw_pkg::WR_ZERO;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.cells_last) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                priority if (i_stat.is_put && i_stat.char_zero) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end else if (i_stat.is_put && i_stat.cur_end) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_COPY;
                end else if (i_stat.is_put && i_stat.char_nl) begin
                    o_cmd.cur_op = tcw_pkg::CUR_NEWLINE;
                    o_cmd.emit   = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_stat.is_put) begin
                    o_cmd.wr_sel = tcw_pkg::WR_CHAR;
                    o_cmd.cur_op = tcw_pkg::CUR_ADVANCE;
                    o_cmd.emit   = 1'b1;
                    n_state      = ST_IDLE;
                end else if (i_stat.is_clear) begin
                    o_cmd.sweep_clr = 1'b1;
                    n_state         = ST_CLEAR;
                end else if (i_stat.is_read && i_stat.idx_ok) begin
                    n_state = ST_READ;
                end else begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_READ: begin
                o_cmd.emit    = 1'b1;
                o_cmd.emit_rd = 1'b1;
                n_state       = ST_IDLE;
            end
            ST_COPY: begin
                // one cell per cycle moves up one row
                o_cmd.rd_copy    = 1'b1;
                o_cmd.copy_issue = 1'b1;
                o_cmd.sweep_inc  = 1'b1;
                if (i_stat.copy_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last copy write lands here
                n_state = ST_FILL;
            end
            ST_FILL: begin
                // blank the last row, then finish the put
                o_cmd.wr_sel    = tcw_pkg::WR_BLANK;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.cells_last) begin
                    o_cmd.sweep_clr = 1'b1;
                    o_cmd.cur_op    = tcw_pkg::CUR_BACK;
                    n_state         = ST_DECODE;
                end
            end
            ST_CLEAR: begin
                o_cmd.wr_sel    = tcw_pkg::WR_BLANK;
                o_cmd.sweep_inc = 1'b1;
                if (i_stat.cells_last) begin
                    o_cmd.sweep_clr = 1'b1;
                    o_cmd.cur_op    = tcw_pkg::CUR_ZERO;
                    o_cmd.emit      = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/tcw_dp.sv @@
// ----------------------------------------------------------------------------
// tcw_dp
// Datapath: screen memory, cursor, sweep counter, attribute register and
// result registers.
// ----------------------------------------------------------------------------
module tcw_dp #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int CUR_W   = $clog2(COLUMNS * ROWS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcw_pkg::t_dp_cmd  i_cmd,
    output tcw_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_req_type,
    input  logic [7:0]        i_char_code,
    input  logic [CUR_W-1:0]  i_cell_index,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    output logic              o_result_valid,
    output logic [CUR_W-1:0]  o_cursor_position,
    output logic [7:0]        o_read_char,
    output logic [7:0]        o_read_attr
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [CUR_W-1:0]  CELLS_C   = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0]  COLS_CUR  = CUR_W'(COLUMNS);
    localparam logic [CUR_W-1:0]  BACK_CUR  = CUR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_COPY = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);

    logic [15:0]       mem [CELLS];

    logic [1:0]        r_req;
    logic [7:0]        r_char;
    logic [CUR_W-1:0]  r_idx;
    logic [CUR_W-1:0]  r_cur;
    logic [CUR_W-1:0]  n_cur;
    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ADDR_W-1:0] r_sweep;
    logic              r_copy_pend;
    logic [ADDR_W-1:0] r_copy_addr;
    logic [15:0]       r_rd_data;
    logic [7:0]        r_attr;
    logic              r_valid;
    logic [CUR_W-1:0]  r_res_cur;
    logic [7:0]        r_res_char;
    logic [7:0]        r_res_attr;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr;

    // Status to the controller
    assign o_stat.is_put     = (r_req == tcw_pkg::REQ_PUT);
    assign o_stat.is_clear   = (r_req == tcw_pkg::REQ_CLEAR);
    assign o_stat.is_read    = (r_req == tcw_pkg::REQ_READ);
    assign o_stat.char_zero  = (r_char == tcw_pkg::CHAR_NUL);
    assign o_stat.char_nl    = (r_char == tcw_pkg::CHAR_NEWLINE);
    assign o_stat.idx_ok     = (r_idx < CELLS_C);
    assign o_stat.cur_end    = (r_cur == CELLS_C);
    assign o_stat.copy_last  = (r_sweep == LAST_COPY);
    assign o_stat.cells_last = (r_sweep == LAST_CELL);

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    assign o_result_valid    = r_valid;
    assign o_cursor_position = r_res_cur;
    assign o_read_char       = r_res_char;
    assign o_read_attr       = r_res_attr;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req  <= i_req_type;
            r_char <= i_char_code;
            r_idx  <= i_cell_index;
        end
    end

    // Attribute register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::ATTR_RESET;
        end else if (i_cfg_valid) begin
            r_attr <= i_cfg_data;
        end
    end

    // Cursor next value; column tracked alongside to avoid a divide
    always_comb begin
        n_cur = r_cur;
        n_col = r_col;
        unique case (i_cmd.cur_op)
            tcw_pkg::CUR_ZERO: begin
                n_cur = '0;
                n_col = '0;
            end
            tcw_pkg::CUR_BACK: begin
                n_cur = BACK_CUR;
                n_col = '0;
            end
            tcw_pkg::CUR_NEWLINE: begin
                n_cur = r_cur + COLS_CUR - CUR_W'(r_col);
                n_col = '0;
            end
            tcw_pkg::CUR_ADVANCE: begin
                n_cur = r_cur + CUR_W'(1);
                n_col = (r_col == LAST_COL) ? '0 : r_col + COL_W'(1);
            end
            default: begin
                n_cur = r_cur;
                n_col = r_col;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_col <= '0;
        end else begin
            r_cur <= n_cur;
            r_col <= n_col;
        end
    end

    // Sweep counter and scroll write tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep     <= '0;
            r_copy_pend <= 1'b0;
        end else begin
            if (i_cmd.sweep_clr) begin
                r_sweep <= '0;
            end else if (i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + ADDR_W'(1);
            end
            r_copy_pend <= i_cmd.copy_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_copy_addr <= r_sweep;
    end

    // Write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_sweep;
        wr_data = '0;
        if (r_copy_pend) begin
            wr_en   = 1'b1;
            wr_addr = r_copy_addr;
            wr_data = r_rd_data;
        end else begin
            unique case (i_cmd.wr_sel)
                tcw_pkg::WR_ZERO: begin
                    wr_en   = 1'b1;
                    wr_data = '0;
                end
                tcw_pkg::WR_BLANK: begin
                    wr_en   = 1'b1;
                    wr_data = {r_attr, tcw_pkg::CHAR_BLANK};
                end
                tcw_pkg::WR_CHAR: begin
                    wr_en   = 1'b1;
                    wr_addr = r_cur[ADDR_W-1:0];
                    wr_data = {r_attr, r_char};
                end
                default: begin
                    wr_en = 1'b0;
                end
            endcase
        end
    end

    assign rd_addr = i_cmd.rd_copy ? (r_sweep + COLS_A) : r_idx[ADDR_W-1:0];

    // Screen memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res_cur  <= n_cur;
            r_res_char <= i_cmd.emit_rd ? r_rd_data[7:0]  : 8'h00;
            r_res_attr <= i_cmd.emit_rd ? r_rd_data[15:8] : 8'h00;
        end
    end

endmodule

@@ hw/rtl/text_console_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_writer
// Character-cell text console: put byte, clear screen and read cell requests
// over a ROWS x COLUMNS screen memory of character/attribute cells.
// ----------------------------------------------------------------------------
// Put (plain byte, newline or zero byte) and out-of-range read: the decode
// state strobes the result (registered) and returns to idle for the next item.
// Read in range: through the read state. Clear: a blank pass over all cells;
// a put that must scroll adds a copy pass and a last-row blank pass, one
// memory port access per cell. Reset: a zeroing pass over all cells with busy
// high; configuration writes are taken meanwhile. The receiver cannot stall.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int CUR_W   = $clog2(COLUMNS * ROWS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_req_type,
    input  logic [7:0]       i_char_code,
    input  logic [CUR_W-1:0] i_cell_index,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [7:0]       i_cfg_data,
    output logic             o_result_valid,
    output logic [CUR_W-1:0] o_cursor_position,
    output logic [7:0]       o_read_char,
    output logic [7:0]       o_read_attr
);

    tcw_pkg::t_dp_cmd  dp_cmd;
    tcw_pkg::t_dp_stat dp_stat;

    // Sequencer
    tcw_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_cmd   (dp_cmd),
        .i_stat  (dp_stat)
    );

    // Memory, cursor and results
    tcw_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .CUR_W   (CUR_W)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_req_type        (i_req_type),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_cursor_position (o_cursor_position),
        .o_read_char       (o_read_char),
        .o_read_attr       (o_read_attr)
    );

endmodule

@@ tb/sv/text_console_writer_tb.sv @@
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A scoreboard class keeps
// its own copy of the screen memory, cursor and attribute, predicts the result
// of every accepted request and checks each strobed result against it.
// Directed requests cover the field extremes and corner cases; the random
// part streams text with newlines, reads, clears and scrolls in bursts, and
// changes the attribute between phases.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS   = tcw_pkg::COLUMNS_DEF;
    localparam int CELLS  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;
    localparam int CUR_W  = $clog2(CELLS + 1);
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 200;
    // worst case is every item scrolling plus the power-up pass, taken 4x
    localparam longint CYCLE_LIMIT = 4 * (2 * CELLS + 64) * 1700 + 4 * CELLS;

    // unused request code
    localparam logic [1:0] REQ_SPARE = 2'd3;

    // read index extremes
    localparam logic [CUR_W-1:0] IDX_LAST = CUR_W'(CELLS - 1);
    localparam logic [CUR_W-1:0] IDX_END  = CUR_W'(CELLS);
    localparam logic [CUR_W-1:0] IDX_MAX  = '1;

    typedef struct packed {
        logic [CUR_W-1:0] cursor;
        logic [7:0]       rd_char;
        logic [7:0]       rd_attr;
    } t_console_result;

    // Console model plus the queue of results still owed by the block
    class console_scoreboard;
        logic [15:0]     screen_mem [CELLS];
        int              cursor;
        logic [7:0]      attr;
        t_console_result pending_results [$];
        int              errors;

        function new();
            for (int i = 0; i < CELLS; i++) screen_mem[i] = '0;
            cursor = 0;
            attr   = tcw_pkg::ATTR_RESET;
            errors = 0;
        endfunction

        function void write_attribute(logic [7:0] value);
            attr = value;
        endfunction

        // apply one accepted request to the model and queue its result
        function void note_request(logic [1:0] req, logic [7:0] ch,
                                   logic [CUR_W-1:0] idx);
            t_console_result res;
            res.rd_char = '0;
            res.rd_attr = '0;
            case (req)
                tcw_pkg::REQ_PUT: begin
                    if (ch != tcw_pkg::CHAR_NUL) begin
                        // past the end: scroll one row first
                        if (cursor >= CELLS) begin
                            for (int i = 0; i < CELLS - COLS; i++)
                                screen_mem[i] = screen_mem[i + COLS];
                            for (int i = CELLS - COLS; i < CELLS; i++)
                                screen_mem[i] = {attr, tcw_pkg::CHAR_BLANK};
                            cursor -= COLS;
                        end
                        if (ch == tcw_pkg::CHAR_NEWLINE) begin
                            cursor = (cursor / COLS + 1) * COLS;
                        end else begin
                            if (cursor < CELLS) screen_mem[cursor] = {attr, ch};
                            cursor++;
                        end
                    end
                end
                tcw_pkg::REQ_CLEAR: begin
                    for (int i = 0; i < CELLS; i++)
                        screen_mem[i] = {attr, tcw_pkg::CHAR_BLANK};
                    cursor = 0;
                end
                tcw_pkg::REQ_READ: begin
                    if (idx < CELLS) begin
                        res.rd_char = screen_mem[idx][7:0];
                        res.rd_attr = screen_mem[idx][15:8];
                    end
                end
                default: ;
            endcase
            res.cursor = cursor[CUR_W-1:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [CUR_W-1:0] cur, logic [7:0] rc,
                                   logic [7:0] ra);
            t_console_result exp_res;
            if (pending_results.size() == 0) begin
                $error("result with nothing expected: cursor %0d char %0h attr %0h",
                       cur, rc, ra);
                errors++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (cur !== exp_res.cursor) begin
                $error("cursor_position: expected %0d, got %0d", exp_res.cursor, cur);
                errors++;
            end
            if (rc !== exp_res.rd_char) begin
                $error("read_char: expected %0h, got %0h", exp_res.rd_char, rc);
                errors++;
            end
            if (ra !== exp_res.rd_attr) begin
                $error("read_attr: expected %0h, got %0h", exp_res.rd_attr, ra);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    logic [1:0]       i_req_type = tcw_pkg::REQ_PUT;
    logic [7:0]       i_char_code = '0;
    logic [CUR_W-1:0] i_cell_index = '0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [7:0]       i_cfg_data = '0;
    logic             o_result_valid;
    logic [CUR_W-1:0] o_cursor_position;
    logic [7:0]       o_read_char;
    logic [7:0]       o_read_attr;

    console_scoreboard sb = new();
    longint            cycle_count = 0;

    text_console_writer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_char_code       (i_char_code),
        .i_cell_index      (i_cell_index),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_result_valid    (o_result_valid),
        .o_cursor_position (o_cursor_position),
        .o_read_char       (o_read_char),
        .o_read_attr       (o_read_attr)
    );

    always #1 i_clk = ~i_clk;

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL text_console_writer");
            $finish;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid)
            sb.check_result(o_cursor_position, o_read_char, o_read_attr);
    end

    // present one item and hold it until taken; start stays high afterwards
    task automatic send_item(logic [1:0] req, logic [7:0] ch, logic [CUR_W-1:0] idx);
        @(negedge i_clk);
        start        = 1'b1;
        i_req_type   = req;
        i_char_code  = ch;
        i_cell_index = idx;
        do @(posedge i_clk); while (busy);
        sb.note_request(req, ch, idx);
    endtask

    task automatic end_burst(int gap);
        @(negedge i_clk);
        start = 1'b0;
        repeat (gap) @(negedge i_clk);
    endtask

    task automatic write_attr_reg(logic [7:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_attribute(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        i_cfg_data  = 8'($urandom_range(0, 255));
    endtask

    task automatic wait_drained();
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // one random request: mostly text, some reads, rare clears
    task automatic random_request(output logic [1:0] req, output logic [7:0] ch,
                                  output logic [CUR_W-1:0] idx);
        int pick;
        int sub;
        int cur;
        pick = $urandom_range(0, 99);
        sub  = $urandom_range(0, 99);
        cur  = sb.cursor;
        ch   = 8'($urandom_range(0, 255));
        idx  = CUR_W'($urandom_range(0, (1 << CUR_W) - 1));
        if (pick < 2) begin
            req = tcw_pkg::REQ_CLEAR;
        end else if (pick < 3) begin
            req = REQ_SPARE;
        end else if (pick < 23) begin
            req = tcw_pkg::REQ_READ;
            if (sub < 55) begin
                // recently written cells near the cursor
                if (cur > COLS) idx = CUR_W'(cur - $urandom_range(1, COLS));
                else idx = CUR_W'($urandom_range(0, (cur > 0) ? cur - 1 : 0));
            end else if (sub < 90) begin
                idx = CUR_W'($urandom_range(0, CELLS - 1));
            end else begin
                idx = CUR_W'($urandom_range(CELLS, (1 << CUR_W) - 1));
            end
        end else begin
            req = tcw_pkg::REQ_PUT;
            if (sub < 12) ch = tcw_pkg::CHAR_NEWLINE;
            else if (sub < 15) ch = tcw_pkg::CHAR_NUL;
            else if (sub < 30) ch = 8'($urandom_range(0, 255));
            else ch = 8'($urandom_range(8'h20, 8'h7E));
        end
    endtask

    initial begin
        logic [1:0]       req;
        logic [7:0]       ch;
        logic [CUR_W-1:0] idx;
        int               left;
        int               burst;
        int               gap;
        int               sel;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty screen, extremes, ignored byte, spare code, clear
        send_item(tcw_pkg::REQ_READ, 8'h00, 0);
        send_item(tcw_pkg::REQ_READ, 8'hFF, IDX_LAST);
        send_item(tcw_pkg::REQ_READ, 8'h00, IDX_END);
        send_item(tcw_pkg::REQ_READ, 8'h00, IDX_MAX);
        send_item(tcw_pkg::REQ_PUT, 8'h41, 0);
        send_item(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NUL, 0);
        send_item(tcw_pkg::REQ_PUT, 8'hFF, IDX_MAX);
        send_item(tcw_pkg::REQ_PUT, 8'h01, 0);
        send_item(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NEWLINE, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, 2);
        send_item(REQ_SPARE, 8'hFF, IDX_MAX);
        end_burst(3);
        send_item(tcw_pkg::REQ_CLEAR, 8'h00, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, IDX_LAST);
        send_item(tcw_pkg::REQ_READ, 8'h00, 0);
        end_burst(0);
        wait_drained();
        write_attr_reg(8'h00);
        send_item(tcw_pkg::REQ_PUT, 8'h80, 0);
        send_item(tcw_pkg::REQ_PUT, tcw_pkg::CHAR_NEWLINE, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, 0);
        end_burst(1);
        wait_drained();
        write_attr_reg(8'hFF);
        send_item(tcw_pkg::REQ_CLEAR, 8'h00, 0);
        send_item(tcw_pkg::REQ_PUT, 8'h5A, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, 0);
        send_item(tcw_pkg::REQ_READ, 8'h00, 5);
        end_burst(0);

        // random phases, attribute changed while idle between them
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph == 0) write_attr_reg(8'h00);
            else if (ph == 1) write_attr_reg(8'hFF);
            else if (ph == 2) write_attr_reg(tcw_pkg::ATTR_RESET);
            else write_attr_reg(8'($urandom_range(0, 255)));
            left = PHASE_ITEMS;
            while (left > 0) begin
                burst = $urandom_range(1, 24);
                if (burst > left) burst = left;
                for (int k = 0; k < burst; k++) begin
                    random_request(req, ch, idx);
                    send_item(req, ch, idx);
                end
                left -= burst;
                sel = $urandom_range(0, 9);
                if (sel < 2) gap = 0;
                else if (sel < 9) gap = $urandom_range(0, 6);
                else gap = $urandom_range(10, 40);
                end_burst(gap);
            end
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("PASS text_console_writer");
        end else begin
            $display("FAIL text_console_writer");
        end
        $finish;
    end

endmodule

@@ text_console_writer.f @@
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_dp.sv
hw/rtl/text_console_writer.sv
tb/sv/text_console_writer_tb.sv
